// File: sv/bkb_pkg.sv
// ----------------------------------------------------------------------------
// bkb_pkg
// Types, codes and helpers shared by the keyboard buffer core.
// ----------------------------------------------------------------------------
package bkb_pkg;

  localparam int SLOT_W     = 5;
  localparam int START_W    = 4;
  localparam int SLOT_COUNT = 1 << SLOT_W;
  localparam int KEY_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SLOT_W;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [START_W-1:0] start_t;
  typedef logic [KEY_W-1:0]   key_t;

  localparam start_t START_SLOT_RESET = start_t'(0);
  localparam slot_t  END_SLOT_RESET   = slot_t'(16);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_CALL = 1'b1;

  localparam logic [7:0] FN_GET       = 8'h00;
  localparam logic [7:0] FN_CHECK     = 8'h01;
  localparam logic [7:0] FN_SHIFT     = 8'h02;
  localparam logic [7:0] FN_FUNC      = 8'h09;
  localparam logic [7:0] FN_GET_ENH   = 8'h10;
  localparam logic [7:0] FN_CHECK_ENH = 8'h11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] function_code;
    logic [7:0] key_ascii;
    logic [7:0] key_scan;
    logic [7:0] shift_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0] al_value;
    logic [7:0] ah_value;
    logic       al_written;
    logic       ah_written;
    logic       zero_flag;
    logic       zf_written;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } ring_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    key_t head;
  } ring_stat_t;

  function automatic slot_t slot_advance(slot_t slot, start_t start_slot, slot_t end_slot);
    logic [SLOT_W:0] nxt;
    nxt = {1'b0, slot} + 1'b1;
    if (nxt >= {1'b0, end_slot}) begin
      nxt = {2'b00, start_slot};
    end
    return nxt[SLOT_W-1:0];
  endfunction

endpackage

// File: sv/bkb_ring.sv
// ----------------------------------------------------------------------------
// bkb_ring
// Key store with read and write pointers, wrap and full/empty status.
// ----------------------------------------------------------------------------
module bkb_ring
  import bkb_pkg::*;
#(
  parameter int BUFFER_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  start_t     start_slot,
  input  slot_t      end_slot,
  input  ring_cmd_t  cmd,
  output ring_stat_t stat
);

  localparam int STORE_DEPTH = (BUFFER_SLOTS < SLOT_COUNT) ? BUFFER_SLOTS : SLOT_COUNT;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  logic [IDX_W-1:0] idx_map [SLOT_COUNT];
  key_t             store_r [STORE_DEPTH];
  slot_t            rd_slot_r, rd_slot_nxt;
  slot_t            wr_slot_r, wr_slot_nxt;
  slot_t            wr_adv;
  slot_t            rd_adv;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_idx_map
    assign idx_map[g] = IDX_W'(g % BUFFER_SLOTS);
  end

  assign wr_adv = slot_advance(wr_slot_r, start_slot, end_slot);
  assign rd_adv = slot_advance(rd_slot_r, start_slot, end_slot);

  assign stat.empty = (rd_slot_r == wr_slot_r);
  assign stat.full  = (wr_adv == rd_slot_r);
  assign stat.head  = store_r[idx_map[rd_slot_r]];

  always_comb begin
    wr_slot_nxt = cmd.push ? wr_adv : wr_slot_r;
    rd_slot_nxt = cmd.pop  ? rd_adv : rd_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r <= slot_t'(START_SLOT_RESET);
      wr_slot_r <= slot_t'(START_SLOT_RESET);
    end else begin
      rd_slot_r <= rd_slot_nxt;
      wr_slot_r <= wr_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store_r[idx_map[wr_slot_r]] <= cmd.key;
    end
  end

endmodule

// File: sv/bkb_decode.sv
// ----------------------------------------------------------------------------
// bkb_decode
// Decodes one held item against the ring status into a result and a
// ring update.
// ----------------------------------------------------------------------------
module bkb_decode
  import bkb_pkg::*;
(
  input  logic       fire,
  input  in_item_t   item,
  input  ring_stat_t stat,
  output out_item_t  result,
  output ring_cmd_t  cmd
);

  always_comb begin
    result   = '0;
    cmd      = '0;
    cmd.key  = {item.key_scan, item.key_ascii};
    if (item.command == CMD_ADD) begin
      if (stat.full) begin
        result.status = ST_FULL;
      end else begin
        cmd.push = fire;
      end
    end else begin
      case (item.function_code)
        FN_GET, FN_GET_ENH: begin
          if (stat.empty) begin
            result.status = ST_EMPTY;
          end else begin
            result.al_value   = stat.head[7:0];
            result.ah_value   = stat.head[15:8];
            result.al_written = 1'b1;
            result.ah_written = 1'b1;
            cmd.pop           = fire;
          end
        end
        FN_CHECK, FN_CHECK_ENH: begin
          result.zf_written = 1'b1;
          if (stat.empty) begin
            result.zero_flag = 1'b1;
          end else begin
            result.al_value   = stat.head[7:0];
            result.ah_value   = stat.head[15:8];
            result.al_written = 1'b1;
            result.ah_written = 1'b1;
          end
        end
        FN_SHIFT: begin
          result.al_value   = item.shift_flags;
          result.al_written = 1'b1;
        end
        FN_FUNC: begin
          result.al_written = 1'b1;
        end
        default: begin
          result.status = ST_UNSUP;
        end
      endcase
    end
  end

endmodule

// File: sv/bios_keyboard_buffer_core.sv
// ----------------------------------------------------------------------------
// bios_keyboard_buffer_core
// Keyboard ring buffer with int 16h call decode.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_item_t  (add key or call)
//   out_     out  out_valid/out_ready  out_item_t (one result per item)
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (start, end slot)
//
// One item per cycle unless out_ready stalls; items pass input and result registers.
// The pointer compare, store read and wrap sit between the input register
// and the result register, so each item sees the pointers left by the last.
// A stalled result holds the input register; in_ready falls only then.
// Reset clears pointers to slot 0 and the region to slots 0 to 15;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module bios_keyboard_buffer_core
  import bkb_pkg::*;
#(
  parameter int BUFFER_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  in_item_t   in_r;
  logic       in_valid_r, in_valid_nxt;
  out_item_t  out_r;
  logic       out_valid_r, out_valid_nxt;
  start_t     start_slot_r;
  slot_t      end_slot_r;
  logic       fire;
  out_item_t  result;
  ring_cmd_t  ring_cmd;
  ring_stat_t ring_stat;

  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      in_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_slot_r <= START_SLOT_RESET;
      end_slot_r   <= END_SLOT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START: start_slot_r <= cfg_data[START_W-1:0];
        CFG_END:   end_slot_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bkb_decode u_decode (
    .fire   (fire),
    .item   (in_r),
    .stat   (ring_stat),
    .result (result),
    .cmd    (ring_cmd)
  );

  bkb_ring #(
    .BUFFER_SLOTS (BUFFER_SLOTS)
  ) u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_slot (start_slot_r),
    .end_slot   (end_slot_r),
    .cmd        (ring_cmd),
    .stat       (ring_stat)
  );

endmodule

// File: sv/bkb_checker.sv
// ----------------------------------------------------------------------------
// bkb_checker
// Port-level checks on the keyboard buffer core, bound to the top level.
// ----------------------------------------------------------------------------
module bkb_checker
  import bkb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      !out_data.al_written && !out_data.ah_written && !out_data.zf_written)
    else $error("failed call wrote a register");

  a_zf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_flag |->
      out_data.zf_written && !out_data.al_written && !out_data.ah_written)
    else $error("empty peek returned a key");

  a_key_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ah_written |-> out_data.al_written)
    else $error("scan code written without ascii");

endmodule

bind bios_keyboard_buffer_core bkb_checker u_bkb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
